[sv/vfc_pkg.sv]
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared constants and types of the valid-mode FIR correlation unit.
// ----------------------------------------------------------------------------
package vfc_pkg;

  localparam int MAX_TAPS_DEF  = 64;
  localparam int SAMPLE_W_DEF  = 16;
  localparam int COEF_W_DEF    = 18;

  localparam int TAP_COUNT_W   = 7;
  localparam int TAP_INDEX_W   = 6;
  localparam int RESULT_W      = 40;

  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = TAP_COUNT_W'(1);

  localparam logic KIND_COEF   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic shift;
    logic rot;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

endpackage

[sv/vfc_ram.sv]
// ----------------------------------------------------------------------------
// vfc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vfc_ram #(
  parameter int WIDTH = vfc_pkg::COEF_W_DEF,
  parameter int DEPTH = vfc_pkg::MAX_TAPS_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/vfc_cell.sv]
// ----------------------------------------------------------------------------
// vfc_cell
// One sample cell of the window ring: shifts in a new sample or rotates.
// ----------------------------------------------------------------------------
module vfc_cell #(
  parameter int SAMPLE_WIDTH = vfc_pkg::SAMPLE_W_DEF
) (
  input  logic                           clk,
  input  vfc_pkg::cell_ctrl_t            ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] shift_in,
  input  logic signed [SAMPLE_WIDTH-1:0] rot_in,
  output logic signed [SAMPLE_WIDTH-1:0] samp
);

  logic signed [SAMPLE_WIDTH-1:0] samp_r;
  logic signed [SAMPLE_WIDTH-1:0] samp_nxt;

  always_comb begin
    samp_nxt = samp_r;
    if (ctrl.shift) begin
      samp_nxt = shift_in;
    end else if (ctrl.rot) begin
      samp_nxt = rot_in;
    end
  end

  always_ff @(posedge clk) begin
    samp_r <= samp_nxt;
  end

  assign samp = samp_r;

endmodule

[sv/vfc_mac.sv]
// ----------------------------------------------------------------------------
// vfc_mac
// Pipelined multiply-accumulate: sample register, product register, 40-bit sum.
// ----------------------------------------------------------------------------
module vfc_mac #(
  parameter int SAMPLE_WIDTH = vfc_pkg::SAMPLE_W_DEF,
  parameter int COEF_WIDTH   = vfc_pkg::COEF_W_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  vfc_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0]     samp,
  input  logic [COEF_WIDTH-1:0]              coef,
  output logic signed [vfc_pkg::RESULT_W-1:0] acc,
  output logic                               busy
);

  localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;

  logic signed [SAMPLE_WIDTH-1:0]      samp_d_r;
  logic signed [PW-1:0]                prod_r;
  logic                                v1_r;
  logic                                v2_r;
  logic signed [vfc_pkg::RESULT_W-1:0] acc_r;
  logic signed [vfc_pkg::RESULT_W-1:0] acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (v2_r) begin
      acc_nxt = acc_r + vfc_pkg::RESULT_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    samp_d_r <= samp;
    prod_r   <= samp_d_r * $signed(coef);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      v1_r  <= ctrl.issue;
      v2_r  <= v1_r;
      acc_r <= acc_nxt;
    end
  end

  assign acc  = acc_r;
  assign busy = v1_r | v2_r;

endmodule

[sv/valid_fir_correlation_unit.sv]
// ----------------------------------------------------------------------------
// valid_fir_correlation_unit
// Valid-mode FIR correlation over a ring of sample cells with one shared MAC.
// ----------------------------------------------------------------------------
// A coefficient load or a sample that does not complete the window leaves the
// input ready. A sample that yields a result holds the input after its
// transaction while the sample ring makes one full turn, presenting one held
// sample to the multiply-accumulate unit per cycle against the coefficient RAM
// read, while the two MAC pipeline stages drain, and until the sum is handed
// to the output register once that register is free. The output register holds
// a result until taken while the next transaction is accepted.
module valid_fir_correlation_unit #(
  parameter int MAX_TAPS     = vfc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = vfc_pkg::SAMPLE_W_DEF,
  parameter int COEF_WIDTH   = vfc_pkg::COEF_W_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [vfc_pkg::TAP_COUNT_W-1:0]     cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic [vfc_pkg::TAP_INDEX_W-1:0]     in_tap_index,
  input  logic signed [COEF_WIDTH-1:0]        in_tap_value,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample,
  input  logic                                in_frame_start,
  input  logic                                in_frame_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [vfc_pkg::RESULT_W-1:0] out_result,
  output logic                                out_last
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TW = $clog2(MAX_TAPS + 1);
  localparam int CW = $clog2(MAX_TAPS + 2);
  localparam logic [CW-1:0] CNT_LAST = CW'(MAX_TAPS + 1);
  localparam logic [CW-1:0] CNT_ROT  = CW'(MAX_TAPS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                              state_r, state_nxt;
  logic [CW-1:0]                       cnt_r, cnt_nxt;
  logic [TW-1:0]                       fill_r, fill_nxt;
  logic [vfc_pkg::TAP_COUNT_W-1:0]     tap_count_r;
  logic                                last_r;
  logic                                out_valid_r, out_valid_nxt;
  logic signed [vfc_pkg::RESULT_W-1:0] out_result_r;
  logic                                out_last_r;

  logic                                in_fire, load_fire, smp_fire, fires, out_load;
  logic [TW-1:0]                       taps_eff;
  logic [CW-1:0]                       taps_ext, rd_idx;
  vfc_pkg::cell_ctrl_t                 cell_ctrl;
  vfc_pkg::mac_ctrl_t                  mac_ctrl;
  logic signed [SAMPLE_WIDTH-1:0]      samp_w [MAX_TAPS];
  logic [COEF_WIDTH-1:0]               coef_q;
  logic signed [vfc_pkg::RESULT_W-1:0] acc;
  logic                                mac_busy;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign load_fire = in_fire && (in_kind == vfc_pkg::KIND_COEF) &&
                     (int'(in_tap_index) < MAX_TAPS);
  assign smp_fire  = in_fire && (in_kind == vfc_pkg::KIND_SAMPLE);

  always_comb begin
    if (tap_count_r == '0) begin
      taps_eff = TW'(1);
    end else if (int'(tap_count_r) > MAX_TAPS) begin
      taps_eff = TW'(MAX_TAPS);
    end else begin
      taps_eff = TW'(tap_count_r);
    end
  end

  always_comb begin
    if (in_frame_start) begin
      fill_nxt = TW'(1);
    end else if (int'(fill_r) < MAX_TAPS) begin
      fill_nxt = fill_r + TW'(1);
    end else begin
      fill_nxt = fill_r;
    end
  end

  assign fires    = smp_fire && (fill_nxt >= taps_eff);
  assign taps_ext = CW'(taps_eff);
  assign rd_idx   = taps_ext - CW'(1) - cnt_r;

  assign cell_ctrl.shift = smp_fire;
  assign cell_ctrl.rot   = (state_r == S_RUN) && (cnt_r < CNT_ROT);
  assign mac_ctrl.clear  = smp_fire;
  assign mac_ctrl.issue  = (state_r == S_RUN) && (cnt_r < taps_ext);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (fires) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      tap_count_r <= vfc_pkg::TAP_COUNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (smp_fire) begin
        fill_r <= fill_nxt;
      end
      if (cfg_wr_en) begin
        tap_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (smp_fire) begin
      last_r <= in_frame_end;
    end
    if (out_load) begin
      out_result_r <= acc;
      out_last_r   <= last_r;
    end
  end

  // Ring: cell 0 holds the newest sample; rotation moves cell k+1 into cell k.
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    vfc_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .shift_in ((k == 0) ? in_sample : samp_w[(k + MAX_TAPS - 1) % MAX_TAPS]),
      .rot_in   (samp_w[(k + 1) % MAX_TAPS]),
      .samp     (samp_w[k])
    );
  end

  vfc_ram #(
    .WIDTH(COEF_WIDTH),
    .DEPTH(MAX_TAPS)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (load_fire),
    .wr_addr (AW'(in_tap_index)),
    .wr_data (in_tap_value),
    .rd_en   (mac_ctrl.issue),
    .rd_addr (AW'(rd_idx)),
    .rd_data (coef_q)
  );

  vfc_mac #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .samp  (samp_w[0]),
    .coef  (coef_q),
    .acc   (acc),
    .busy  (mac_busy)
  );

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_last   = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (int'(cnt_r) <= MAX_TAPS + 1))
    else $error("ring counter out of range");

  a_mac_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> !mac_busy)
    else $error("MAC pipeline busy when result is taken");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside completion");

  a_fire_runs: assert property (@(posedge clk) disable iff (!rst_n)
    fires |=> (state_r == S_RUN) && (cnt_r == '0))
    else $error("completing sample did not start accumulation");

endmodule
